// ===== src/plc_pkg.sv =====
// Package for the positional list engine: request/result transfer types,
// action, status, cell and sequencer codes. No dependencies.
package plc_pkg;

	localparam int ACTION_W = 3;
	localparam int POS_W    = 7;
	localparam int ENTRY_W  = 16;
	localparam int STATUS_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_READ   = 3'd2,
		ACT_MOVE   = 3'd3,
		ACT_CLEAR  = 3'd4
	} plc_action_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} plc_status_e;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} plc_cell_op_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_COLLECT
	} plc_state_e;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [POS_W-1:0]    position;
		logic [POS_W-1:0]    second_position;
		logic [ENTRY_W-1:0]  entry_in;
	} plc_req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0]  entry_out;
		logic [POS_W-1:0]    entry_count;
		logic [STATUS_W-1:0] status;
	} plc_rsp_t;

endpackage

// ===== src/positional_list_engine_unit.sv =====
// Positional list engine top level: sequencer, row of list cells, tap gather.
// Depends on plc_pkg, plc_cell and plc_gather.
//
// Usage:
//   req channel (req_valid/req_stall/req) carries one action per transfer;
//   rsp channel (rsp_valid/rsp_stall/rsp) returns one result per request.
//   The list is a row of CAPACITY cells; insert and remove shift the cells
//   at and above the position in parallel, so list length does not affect timing.
//   Insert, clear, rejected and unknown actions: the result is loaded from
//   the execute state, and the sequencer then returns to idle.
//   Read, remove and move: the selected cell is fetched through a registered
//   OR tree, adding a collect state before the result is loaded.
//   Move removes in the execute state and reinserts in the collect state.
//   req_stall is low whenever the sequencer is idle, also while a result
//   waits in the output register. A stalled result holds; a request that
//   completes while the output is stalled waits before touching the list.
//   Reset empties the list (count zero); entry contents are not cleared,
//   since only positions below the count are ever read.
module positional_list_engine_unit #(
	parameter int CAPACITY    = 64,
	parameter int ENTRY_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  plc_pkg::plc_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output plc_pkg::plc_rsp_t rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = plc_pkg::POS_W;
	localparam int EW = plc_pkg::ENTRY_W;
	localparam int XW = (CW > PW) ? CW : PW;
	localparam int SW = (ENTRY_WIDTH < EW) ? ENTRY_WIDTH : EW;

	plc_pkg::plc_state_e state_q, state_d;

	logic [plc_pkg::ACTION_W-1:0] act_q;
	logic [PW-1:0]                pos_q;
	logic [PW-1:0]                pos2_q;
	logic [SW-1:0]                word_q;
	logic [CW-1:0]                count_q, count_d;
	logic                         rsp_valid_q;
	plc_pkg::plc_rsp_t            rsp_q, rsp_d;
	logic                         rsp_load;

	logic [XW-1:0]         pos_x, pos2_x, cnt_x;
	logic                  pos_ok, full, out_free, accept, capture;
	logic [IW-1:0]         rd_idx, ins_idx_a, ins_idx_b;
	plc_pkg::plc_cell_op_e cell_op;
	logic [IW-1:0]         cell_idx;
	logic [SW-1:0]         cell_word;
	logic [SW-1:0]         gathered;

	logic [CAPACITY-1:0][SW-1:0] cell_q;
	logic [CAPACITY-1:0][SW-1:0] cell_tap;

	function automatic logic [IW-1:0] clamp_idx(logic [XW-1:0] p, logic [XW-1:0] c);
		logic [IW-1:0] r;
		if (p <= XW'(1)) begin
			r = '0;
		end else if (p > c) begin
			r = IW'(c);
		end else begin
			r = IW'(p - XW'(1));
		end
		return r;
	endfunction

	assign pos_x     = XW'(pos_q);
	assign pos2_x    = XW'(pos2_q);
	assign cnt_x     = XW'(count_q);
	assign pos_ok    = (cnt_x != '0) && (pos_x != '0) && (pos_x <= cnt_x);
	assign full      = (count_q == CW'(CAPACITY));
	assign rd_idx    = IW'(pos_x - XW'(1));
	assign ins_idx_a = clamp_idx(pos_x, cnt_x);
	assign ins_idx_b = clamp_idx(pos2_x, cnt_x);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != plc_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;

	always_comb begin
		state_d          = state_q;
		count_d          = count_q;
		cell_op          = plc_pkg::CELL_HOLD;
		cell_idx         = rd_idx;
		cell_word        = word_q;
		capture          = 1'b0;
		rsp_load         = 1'b0;
		rsp_d.entry_out  = '0;
		rsp_d.status     = plc_pkg::ST_OK;
		case (state_q)
			plc_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = plc_pkg::S_EXEC;
				end
			end
			plc_pkg::S_EXEC: begin
				if (out_free) begin
					state_d  = plc_pkg::S_IDLE;
					rsp_load = 1'b1;
					case (act_q)
						plc_pkg::ACT_INSERT: begin
							if (full) begin
								rsp_d.status = plc_pkg::ST_FULL;
							end else begin
								cell_op  = plc_pkg::CELL_INSERT;
								cell_idx = ins_idx_a;
								count_d  = count_q + CW'(1);
							end
						end
						plc_pkg::ACT_REMOVE, plc_pkg::ACT_MOVE: begin
							if (pos_ok) begin
								cell_op  = plc_pkg::CELL_REMOVE;
								count_d  = count_q - CW'(1);
								capture  = 1'b1;
								rsp_load = 1'b0;
								state_d  = plc_pkg::S_COLLECT;
							end else begin
								rsp_d.status = plc_pkg::ST_RANGE;
							end
						end
						plc_pkg::ACT_READ: begin
							if (pos_ok) begin
								capture  = 1'b1;
								rsp_load = 1'b0;
								state_d  = plc_pkg::S_COLLECT;
							end else begin
								rsp_d.status = plc_pkg::ST_RANGE;
							end
						end
						plc_pkg::ACT_CLEAR: begin
							count_d = '0;
						end
						default: begin
							count_d = count_q;
						end
					endcase
				end
			end
			plc_pkg::S_COLLECT: begin
				if (out_free) begin
					state_d         = plc_pkg::S_IDLE;
					rsp_load        = 1'b1;
					rsp_d.entry_out = EW'(gathered);
					if (act_q == plc_pkg::ACT_MOVE) begin
						cell_op   = plc_pkg::CELL_INSERT;
						cell_idx  = ins_idx_b;
						cell_word = gathered;
						count_d   = count_q + CW'(1);
					end
				end
			end
			default: begin
				state_d = plc_pkg::S_IDLE;
			end
		endcase
		rsp_d.entry_count = PW'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plc_pkg::S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= req.action;
			pos_q  <= req.position;
			pos2_q <= req.second_position;
			word_q <= req.entry_in[SW-1:0];
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [SW-1:0] left_w;
		logic [SW-1:0] right_w;
		if (i == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_q[i+1];
		end
		plc_cell #(
			.INDEX (i),
			.IW    (IW),
			.SW    (SW)
		) u_cell (
			.clk   (clk),
			.op    (cell_op),
			.idx   (cell_idx),
			.word  (cell_word),
			.left  (left_w),
			.right (right_w),
			.q     (cell_q[i]),
			.tap   (cell_tap[i])
		);
	end

	plc_gather #(
		.N  (CAPACITY),
		.SW (SW)
	) u_gather (
		.clk     (clk),
		.capture (capture),
		.taps    (cell_tap),
		.word    (gathered)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list count exceeds capacity");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == plc_pkg::S_IDLE |=> $stable(count_q))
		else $error("count changed with no request in flight");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == plc_pkg::S_EXEC)
		else $error("accepted request not executed");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == plc_pkg::ST_RANGE |-> rsp.entry_out == '0)
		else $error("rejected request returned an entry");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == plc_pkg::ST_FULL |-> rsp.entry_count == PW'(CAPACITY))
		else $error("full status with list not full");
`endif

endmodule

// ===== src/plc_cell.sv =====
// One list cell: holds the entry at a fixed position and shifts, holds or loads.
// Depends on plc_pkg for the cell operation codes.
module plc_cell #(
	parameter int INDEX = 0,
	parameter int IW    = 6,
	parameter int SW    = 16
) (
	input  logic                  clk,
	input  plc_pkg::plc_cell_op_e op,
	input  logic [IW-1:0]         idx,
	input  logic [SW-1:0]         word,
	input  logic [SW-1:0]         left,
	input  logic [SW-1:0]         right,
	output logic [SW-1:0]         q,
	output logic [SW-1:0]         tap
);

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic [SW-1:0] entry_q;
	logic [SW-1:0] entry_d;

	always_comb begin
		entry_d = entry_q;
		case (op)
			plc_pkg::CELL_INSERT: begin
				if (MY_IDX > idx) begin
					entry_d = left;
				end else if (MY_IDX == idx) begin
					entry_d = word;
				end
			end
			plc_pkg::CELL_REMOVE: begin
				if (MY_IDX >= idx) begin
					entry_d = right;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign q   = entry_q;
	assign tap = (MY_IDX == idx) ? entry_q : '0;

endmodule

// ===== src/plc_gather.sv =====
// Registered OR tree that collects the one selected cell tap into a word.
// Groups of eight taps are reduced and registered, then merged. No dependencies.
module plc_gather #(
	parameter int N  = 64,
	parameter int SW = 16
) (
	input  logic                  clk,
	input  logic                  capture,
	input  logic [N-1:0][SW-1:0]  taps,
	output logic [SW-1:0]         word
);

	localparam int GROUPS = (N + 7) / 8;

	logic [GROUPS-1:0][SW-1:0] grp_d;
	logic [GROUPS-1:0][SW-1:0] grp_q;

	always_comb begin
		grp_d = '0;
		for (int g = 0; g < GROUPS; g++) begin
			for (int k = 0; k < 8; k++) begin
				if (g * 8 + k < N) begin
					grp_d[g] = grp_d[g] | taps[g * 8 + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			grp_q <= grp_d;
		end
	end

	always_comb begin
		word = '0;
		for (int g = 0; g < GROUPS; g++) begin
			word = word | grp_q[g];
		end
	end

endmodule
